// ===== src/swrm_pkg.sv =====
// ----------------------------------------------------------------------------
// swrm_pkg: shared types and constants of the sliding window rate meter
// Field widths, item kinds, averaging scale and the packed result layout.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int DEFAULT_WINDOW_UNITS = 16;

    localparam int FUNC_W      = 2;
    localparam int AMOUNT_W    = 16;
    localparam int SLOT_B_W    = 32;
    localparam int SLOT_P_W    = 24;
    localparam int WIN_B_W     = 40;
    localparam int WIN_P_W     = 32;
    localparam int TOT_B_W     = 48;
    localparam int TOT_P_W     = 32;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 32;

    // averages scale by 1000 = 2**10 - 24
    localparam int AVG_SCALE   = 1000;
    localparam int SCALE_SHIFT = 10;
    localparam int DIV_B_W     = TOT_B_W + SCALE_SHIFT;
    localparam int DIV_P_W     = TOT_P_W + SCALE_SHIFT;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_UNIT   = 2'd1,
        FUNC_MS     = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // first field in the highest bits
    typedef struct packed {
        logic [RATE_W-1:0]  peak_packet_rate;
        logic [RATE_W-1:0]  peak_byte_rate;
        logic [RATE_W-1:0]  average_packet_rate;
        logic [RATE_W-1:0]  average_byte_rate;
        logic [RATE_W-1:0]  packet_rate;
        logic [RATE_W-1:0]  byte_rate;
        logic [TOT_P_W-1:0] out_total_packets;
        logic [TOT_B_W-1:0] out_total_bytes;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

// ===== src/swrm_ram.sv =====
// ----------------------------------------------------------------------------
// swrm_ram: generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/swrm_div.sv =====
// ----------------------------------------------------------------------------
// swrm_div: bit-serial restoring divider
// One quotient bit per cycle; quotient saturated to the rate width.
// ----------------------------------------------------------------------------
module swrm_div #(
    parameter int DW = swrm_pkg::DIV_B_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [swrm_pkg::RATE_W-1:0] divisor,
    output logic                        busy,
    output logic [swrm_pkg::RATE_W-1:0] quotient
);

    localparam int RW = swrm_pkg::RATE_W;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [DW-1:0] quo_reg;
    logic [RW-1:0] div_reg;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          take;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, div_reg};
        take     = (trial >= {1'b0, div_reg});
        rem_next = take ? diff[RW-1:0] : trial[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = (|quo_reg[DW-1:RW]) ? '1 : quo_reg[RW-1:0];

endmodule

// ===== src/sliding_window_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_top: sliding window traffic rate meter
// Lifetime totals, windowed rates over a ring of unit slots, peaks and
// long-run averages; one result item per input item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser func, s_tdata amount
//  m_*       out  m_tvalid/m_tready  m_tdata eight result fields
//
//  Records, millisecond ticks and idle kinds each run the bit-serial average
//  division (48+10 quotient bits) before the next item is accepted. Unit
//  ticks run the window division through the same dividers first.
//  After reset all WINDOW_UNITS+1 slot RAM entries are zeroed, with s_tready low.
//  A waiting result sits in the output register; the next item is taken
//  meanwhile, and only its own result waits for m_tready.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_top #(
    parameter int WINDOW_UNITS = swrm_pkg::DEFAULT_WINDOW_UNITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swrm_pkg::AMOUNT_W-1:0] s_tdata,   // amount
    input  logic [swrm_pkg::FUNC_W-1:0]   s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_total_bytes, out_total_packets, byte_rate, packet_rate,
    // average_byte_rate, average_packet_rate, peak_byte_rate, peak_packet_rate
    output logic [swrm_pkg::RES_W-1:0]    m_tdata
);

    localparam int RING  = WINDOW_UNITS + 1;
    localparam int IW    = $clog2(RING);
    localparam int SBW   = swrm_pkg::SLOT_B_W;
    localparam int SPW   = swrm_pkg::SLOT_P_W;
    localparam int WBW   = swrm_pkg::WIN_B_W;
    localparam int WPW   = swrm_pkg::WIN_P_W;
    localparam int TBW   = swrm_pkg::TOT_B_W;
    localparam int TPW   = swrm_pkg::TOT_P_W;
    localparam int TW    = swrm_pkg::TIME_W;
    localparam int RW    = swrm_pkg::RATE_W;
    localparam int AW    = swrm_pkg::AMOUNT_W;
    localparam int DBW   = swrm_pkg::DIV_B_W;
    localparam int DPW   = swrm_pkg::DIV_P_W;
    localparam int SH    = swrm_pkg::SCALE_SHIFT;
    localparam int SLOTW = SBW + SPW;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_REC,
        ST_TICK_A,
        ST_TICK_B,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_MUL,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [IW-1:0]            clr_idx_reg;
    logic [IW-1:0]            slot_idx_reg;
    logic [IW-1:0]            next_idx;
    swrm_pkg::func_t          func_reg;
    logic [AW-1:0]            amount_reg;
    logic [WBW-1:0]           win_b_reg;
    logic [WPW-1:0]           win_p_reg;
    logic [TBW-1:0]           tot_b_reg;
    logic [TPW-1:0]           tot_p_reg;
    logic [RW-1:0]            cur_b_reg;
    logic [RW-1:0]            cur_p_reg;
    logic [RW-1:0]            peak_b_reg;
    logic [RW-1:0]            peak_p_reg;
    logic [TW-1:0]            elapsed_reg;
    logic [DBW-1:0]           p24_b_reg;
    logic [DPW-1:0]           p24_p_reg;
    logic                     m_tvalid_reg;
    swrm_pkg::result_t        m_tdata_reg;

    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    logic [SLOTW-1:0]         ram_wdata;
    logic [IW-1:0]            ram_raddr;
    logic [SLOTW-1:0]         ram_rdata;
    logic [SBW-1:0]           rd_b;
    logic [SPW-1:0]           rd_p;

    logic [TBW:0]             tot_b_sum;
    logic [TBW-1:0]           tot_b_next;
    logic [TPW-1:0]           tot_p_next;
    logic [SBW:0]             slot_b_sum;
    logic [SBW-1:0]           slot_b_next;
    logic [SPW-1:0]           slot_p_next;
    logic [WBW:0]             win_b_sum;
    logic [WPW:0]             win_p_sum;
    logic [WBW-1:0]           win_b_next;
    logic [WPW-1:0]           win_p_next;
    logic [TW-1:0]            elapsed_next;

    logic                     div_start;
    logic [DBW-1:0]           div_b_in;
    logic [DPW-1:0]           div_p_in;
    logic [RW-1:0]            divisor;
    logic                     div_b_busy;
    logic                     div_p_busy;
    logic [RW-1:0]            q_b;
    logic [RW-1:0]            q_p;
    logic                     out_free;

    assign rd_b     = ram_rdata[SBW-1:0];
    assign rd_p     = ram_rdata[SLOTW-1:SBW];
    assign next_idx = (slot_idx_reg == IW'(RING - 1)) ? '0 : slot_idx_reg + IW'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    swrm_ram #(
        .WIDTH (SLOTW),
        .DEPTH (RING)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swrm_div #(
        .DW (DBW)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_b_in),
        .divisor  (divisor),
        .busy     (div_b_busy),
        .quotient (q_b)
    );

    swrm_div #(
        .DW (DPW)
    ) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_p_in),
        .divisor  (divisor),
        .busy     (div_p_busy),
        .quotient (q_p)
    );

    always_comb
    begin
        tot_b_sum    = {1'b0, tot_b_reg} + (TBW + 1)'(amount_reg);
        tot_b_next   = tot_b_sum[TBW] ? '1 : tot_b_sum[TBW-1:0];
        tot_p_next   = (&tot_p_reg) ? tot_p_reg : tot_p_reg + TPW'(1);
        slot_b_sum   = {1'b0, rd_b} + (SBW + 1)'(amount_reg);
        slot_b_next  = slot_b_sum[SBW] ? '1 : slot_b_sum[SBW-1:0];
        slot_p_next  = (&rd_p) ? rd_p : rd_p + SPW'(1);
        win_b_sum    = {1'b0, win_b_reg} + (WBW + 1)'(rd_b);
        win_p_sum    = {1'b0, win_p_reg} + (WPW + 1)'(rd_p);
        win_b_next   = (win_b_reg >= WBW'(rd_b)) ? win_b_reg - WBW'(rd_b) : '0;
        win_p_next   = (win_p_reg >= WPW'(rd_p)) ? win_p_reg - WPW'(rd_p) : '0;
        elapsed_next = (&elapsed_reg) ? elapsed_reg : elapsed_reg + TW'(1);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_idx_reg;
        ram_wdata = '0;
        ram_raddr = slot_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
            end
            ST_REC:
            begin
                ram_we    = 1'b1;
                ram_wdata = {slot_p_next, slot_b_next};
            end
            ST_TICK_A:
            begin
                ram_raddr = next_idx;
            end
            ST_TICK_B:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // 1000*t = (t << 10) - 24*t
    always_comb
    begin
        div_start = (state_reg == ST_RATE_GO) || (state_reg == ST_AVG_GO);
        if (state_reg == ST_RATE_GO)
        begin
            div_b_in = DBW'(win_b_reg);
            div_p_in = DPW'(win_p_reg);
            divisor  = RW'(WINDOW_UNITS);
        end
        else
        begin
            div_b_in = (DBW'(tot_b_reg) << SH) - p24_b_reg;
            div_p_in = (DPW'(tot_p_reg) << SH) - p24_p_reg;
            divisor  = (elapsed_reg < TW'(swrm_pkg::AVG_SCALE))
                     ? RW'(swrm_pkg::AVG_SCALE) : RW'(elapsed_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            slot_idx_reg <= '0;
            func_reg     <= swrm_pkg::FUNC_NONE;
            amount_reg   <= '0;
            win_b_reg    <= '0;
            win_p_reg    <= '0;
            tot_b_reg    <= '0;
            tot_p_reg    <= '0;
            cur_b_reg    <= '0;
            cur_p_reg    <= '0;
            peak_b_reg   <= '0;
            peak_p_reg   <= '0;
            elapsed_reg  <= '0;
            p24_b_reg    <= '0;
            p24_p_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IW'(1);
                    if (clr_idx_reg == IW'(RING - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg   <= swrm_pkg::func_t'(s_tuser);
                        amount_reg <= s_tdata;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    unique case (func_reg)
                        swrm_pkg::FUNC_RECORD: state_reg <= ST_REC;
                        swrm_pkg::FUNC_UNIT:   state_reg <= ST_TICK_A;
                        swrm_pkg::FUNC_MS:
                        begin
                            elapsed_reg <= elapsed_next;
                            state_reg   <= ST_MUL;
                        end
                        swrm_pkg::FUNC_NONE:   state_reg <= ST_MUL;
                    endcase
                end
                ST_REC:
                begin
                    tot_b_reg <= tot_b_next;
                    tot_p_reg <= tot_p_next;
                    state_reg <= ST_MUL;
                end
                ST_TICK_A:
                begin
                    win_b_reg    <= win_b_sum[WBW] ? '1 : win_b_sum[WBW-1:0];
                    win_p_reg    <= win_p_sum[WPW] ? '1 : win_p_sum[WPW-1:0];
                    slot_idx_reg <= next_idx;
                    state_reg    <= ST_TICK_B;
                end
                ST_TICK_B:
                begin
                    win_b_reg <= win_b_next;
                    win_p_reg <= win_p_next;
                    state_reg <= ST_RATE_GO;
                end
                ST_RATE_GO:
                begin
                    state_reg <= ST_RATE_WAIT;
                end
                ST_RATE_WAIT:
                begin
                    if (!div_b_busy && !div_p_busy)
                    begin
                        cur_b_reg <= q_b;
                        cur_p_reg <= q_p;
                        if (q_b > peak_b_reg)
                        begin
                            peak_b_reg <= q_b;
                        end
                        if (q_p > peak_p_reg)
                        begin
                            peak_p_reg <= q_p;
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    p24_b_reg <= (DBW'(tot_b_reg) << 4) + (DBW'(tot_b_reg) << 3);
                    p24_p_reg <= (DPW'(tot_p_reg) << 4) + (DPW'(tot_p_reg) << 3);
                    state_reg <= ST_AVG_GO;
                end
                ST_AVG_GO:
                begin
                    state_reg <= ST_AVG_WAIT;
                end
                ST_AVG_WAIT:
                begin
                    if (!div_b_busy && !div_p_busy)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg.out_total_bytes     <= tot_b_reg;
                        m_tdata_reg.out_total_packets   <= tot_p_reg;
                        m_tdata_reg.byte_rate           <= cur_b_reg;
                        m_tdata_reg.packet_rate         <= cur_p_reg;
                        m_tdata_reg.average_byte_rate   <= q_b;
                        m_tdata_reg.average_packet_rate <= q_p;
                        m_tdata_reg.peak_byte_rate      <= peak_b_reg;
                        m_tdata_reg.peak_packet_rate    <= peak_p_reg;
                        m_tvalid_reg                    <= 1'b1;
                        state_reg                       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/rate_meter_checker.sv =====
// ----------------------------------------------------------------------------
// rate_meter_checker: result checker for the sliding window rate meter
// Watches both stream channels. Every accepted input item is run through a
// local model of the slot ring, window sums, totals, peaks and averages. The
// predicted result goes onto a queue, and each accepted output item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rate_meter_checker
    import swrm_pkg::*;
#(
    parameter int WINDOW_UNITS = DEFAULT_WINDOW_UNITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [AMOUNT_W-1:0] s_tdata,   // amount
    input  logic [FUNC_W-1:0]   s_tuser,   // func
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [RES_W-1:0]    m_tdata,
    output int                  errors,
    output int                  pending
);

    localparam int RING = WINDOW_UNITS + 1;
    localparam logic [63:0] MAX24 = 64'hFF_FFFF;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

    logic [SLOT_B_W-1:0] ring_bytes [RING];
    logic [SLOT_P_W-1:0] ring_pkts  [RING];
    int                  ring_pos;
    logic [WIN_B_W-1:0]  win_bytes;
    logic [WIN_P_W-1:0]  win_pkts;
    logic [TOT_B_W-1:0]  life_bytes;
    logic [TOT_P_W-1:0]  life_pkts;
    logic [RATE_W-1:0]   rate_bytes;
    logic [RATE_W-1:0]   rate_pkts;
    logic [RATE_W-1:0]   peak_bytes;
    logic [RATE_W-1:0]   peak_pkts;
    logic [TIME_W-1:0]   elapsed_ms;

    result_t predicted_results [$];
    int      mismatches = 0;
    int      outstanding = 0;

    assign errors  = mismatches;
    assign pending = outstanding;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] lim);
        logic [63:0] s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    function automatic logic [RATE_W-1:0] sat32(input logic [63:0] v);
        return (v > MAX32) ? MAX32[RATE_W-1:0] : v[RATE_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] long_run_rate(input logic [63:0] total);
        logic [63:0] span;
        span = (elapsed_ms < TIME_W'(AVG_SCALE)) ? 64'(AVG_SCALE) : 64'(elapsed_ms);
        return sat32((total * 64'(AVG_SCALE)) / span);
    endfunction

    // advances the model by one item and returns the result it causes
    function automatic result_t meter_predict(input func_t f,
                                              input logic [AMOUNT_W-1:0] amount);
        int          last;
        int          nxt;
        logic [63:0] wb;
        logic [63:0] wp;
        result_t     r;
        case (f)
            FUNC_RECORD:
            begin
                life_bytes = TOT_B_W'(sat_add(64'(life_bytes), 64'(amount), MAX48));
                life_pkts  = TOT_P_W'(sat_add(64'(life_pkts), 64'd1, MAX32));
                ring_bytes[ring_pos] = SLOT_B_W'(sat_add(64'(ring_bytes[ring_pos]),
                                                         64'(amount), MAX32));
                ring_pkts[ring_pos]  = SLOT_P_W'(sat_add(64'(ring_pkts[ring_pos]),
                                                         64'd1, MAX24));
            end
            FUNC_UNIT:
            begin
                last = ring_pos;
                nxt  = (last + 1 >= RING) ? 0 : last + 1;
                ring_pos = nxt;
                wb = sat_add(64'(win_bytes), 64'(ring_bytes[last]), MAX40);
                wp = sat_add(64'(win_pkts), 64'(ring_pkts[last]), MAX32);
                // reused slot leaves the window, floored at zero
                wb = (wb >= 64'(ring_bytes[nxt])) ? wb - 64'(ring_bytes[nxt]) : 64'd0;
                wp = (wp >= 64'(ring_pkts[nxt])) ? wp - 64'(ring_pkts[nxt]) : 64'd0;
                ring_bytes[nxt] = '0;
                ring_pkts[nxt]  = '0;
                win_bytes  = wb[WIN_B_W-1:0];
                win_pkts   = wp[WIN_P_W-1:0];
                rate_bytes = sat32(wb / 64'(WINDOW_UNITS));
                rate_pkts  = sat32(wp / 64'(WINDOW_UNITS));
                if (rate_bytes > peak_bytes)
                    peak_bytes = rate_bytes;
                if (rate_pkts > peak_pkts)
                    peak_pkts = rate_pkts;
            end
            FUNC_MS:
                elapsed_ms = TIME_W'(sat_add(64'(elapsed_ms), 64'd1, MAX32));
            default:
                ;
        endcase
        r.out_total_bytes     = life_bytes;
        r.out_total_packets   = life_pkts;
        r.byte_rate           = rate_bytes;
        r.packet_rate         = rate_pkts;
        r.average_byte_rate   = long_run_rate(64'(life_bytes));
        r.average_packet_rate = long_run_rate(64'(life_pkts));
        r.peak_byte_rate      = peak_bytes;
        r.peak_packet_rate    = peak_pkts;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("rate meter: %s expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < RING; i++)
            begin
                ring_bytes[i] = '0;
                ring_pkts[i]  = '0;
            end
            ring_pos   = 0;
            win_bytes  = '0;
            win_pkts   = '0;
            life_bytes = '0;
            life_pkts  = '0;
            rate_bytes = '0;
            rate_pkts  = '0;
            peak_bytes = '0;
            peak_pkts  = '0;
            elapsed_ms = '0;
            predicted_results.delete();
            outstanding = 0;
        end
        else
        begin
            // compare before queueing, so a new item never meets its own result
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("rate meter: result item %0h with none predicted", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    got  = result_t'(m_tdata);
                    check_field("out_total_bytes", 64'(want.out_total_bytes),
                                64'(got.out_total_bytes));
                    check_field("out_total_packets", 64'(want.out_total_packets),
                                64'(got.out_total_packets));
                    check_field("byte_rate", 64'(want.byte_rate), 64'(got.byte_rate));
                    check_field("packet_rate", 64'(want.packet_rate),
                                64'(got.packet_rate));
                    check_field("average_byte_rate", 64'(want.average_byte_rate),
                                64'(got.average_byte_rate));
                    check_field("average_packet_rate", 64'(want.average_packet_rate),
                                64'(got.average_packet_rate));
                    check_field("peak_byte_rate", 64'(want.peak_byte_rate),
                                64'(got.peak_byte_rate));
                    check_field("peak_packet_rate", 64'(want.peak_packet_rate),
                                64'(got.peak_packet_rate));
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(meter_predict(func_t'(s_tuser), s_tdata));
            outstanding = predicted_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top of the sliding window rate meter
// Drives directed items, then random packet records, unit ticks, millisecond
// ticks and unused kinds in bursts with random gaps, including a long run of
// millisecond ticks so that elapsed time passes one second. The output side
// stalls on its own changing pattern. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import swrm_pkg::*;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_MASK,
        READY_SLOW
    } ready_mode_t;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1180;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [AMOUNT_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RES_W-1:0]    m_tdata;

    int                  errors;
    int                  pending;
    int                  idle_cycles = 0;
    int                  burst_left = 0;
    logic [15:0]         stall_tick = '0;
    logic [15:0]         ready_mask = 16'hFFFF;
    ready_mode_t         ready_mode = READY_ALWAYS;

    sliding_window_rate_meter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rate_meter_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // output stalls: pattern changes whenever the low byte of stall_tick is zero
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[7:0] == 8'd0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_mask <= 16'($urandom) | 16'h0001;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_MASK:   m_tready <= ready_mask[stall_tick[3:0]];
            default:      m_tready <= (stall_tick[3:0] == 4'd0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_item(input func_t f, input logic [AMOUNT_W-1:0] amount);
        s_tuser  <= f;
        s_tdata  <= amount;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 8);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge clk);
        end
    endtask

    initial
    begin
        func_t               f;
        logic [AMOUNT_W-1:0] amount;
        int                  pick;
        bit                  tick_heavy;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: amount extremes, every kind, unused kind with data
        send_item(FUNC_RECORD, 16'h0000);
        send_item(FUNC_RECORD, 16'hFFFF);
        send_item(FUNC_RECORD, 16'h0001);
        send_item(FUNC_RECORD, 16'h8000);
        send_item(FUNC_NONE,   16'hFFFF);
        send_item(FUNC_UNIT,   16'h0000);
        send_item(FUNC_RECORD, 16'h5555);
        send_item(FUNC_RECORD, 16'hAAAA);
        send_item(FUNC_MS,     16'hFFFF);
        send_item(FUNC_UNIT,   16'hFFFF);
        send_item(FUNC_NONE,   16'h0000);
        send_item(FUNC_RECORD, 16'hFFFF);
        send_item(FUNC_MS,     16'h0000);
        send_item(FUNC_UNIT,   16'h1234);
        send_item(FUNC_UNIT,   16'h0000);
        send_item(FUNC_RECORD, 16'h7FFF);
        send_item(FUNC_UNIT,   16'h0000);

        // random; the middle stretch is mostly millisecond ticks so that
        // elapsed time passes one second and the averages divide by it
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            tick_heavy = (i >= 100) && (i < 1150);
            pick = $urandom_range(0, 99);
            if (tick_heavy)
                f = (pick < 1) ? FUNC_RECORD : (pick < 2) ? FUNC_UNIT :
                    (pick < 99) ? FUNC_MS : FUNC_NONE;
            else
                f = (pick < 50) ? FUNC_RECORD : (pick < 75) ? FUNC_UNIT :
                    (pick < 95) ? FUNC_MS : FUNC_NONE;
            case ($urandom_range(0, 19))
                0:       amount = '0;
                1:       amount = '1;
                default: amount = AMOUNT_W'($urandom_range(0, 65535));
            endcase
            send_item(f, amount);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
